@@ rtl/rsq_pkg.sv @@
// shared types and constants of the packet resequencer
package rsq_pkg;

  localparam int unsigned WindowDefault  = 64;
  localparam int unsigned PendingDefault = 8;
  localparam int unsigned MaxResults     = 64;
  localparam int unsigned ResCntW        = $clog2(MaxResults + 1);
  localparam int unsigned PendCntW       = 5;

  localparam logic [1:0] CfgTotal     = 2'd0;
  localparam logic [1:0] CfgThreshold = 2'd1;
  localparam logic [1:0] CfgMaxPend   = 2'd2;

  typedef enum logic [2:0] {
    KIND_DELIVER  = 3'd0,
    KIND_REQUEST  = 3'd1,
    KIND_DROP     = 3'd2,
    KIND_REJECT   = 3'd3,
    KIND_COMPLETE = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
  } res_t;

  typedef struct packed {
    logic        clr;
    logic        alloc;
    logic [31:0] seq;
  } pend_cmd_t;

  typedef struct packed {
    logic                known;
    logic                free_found;
    logic [PendCntW-1:0] count;
  } pend_stat_t;

endpackage

@@ rtl/rsq_pend.sv @@
// table of outstanding retransmission requests
module rsq_pend
  import rsq_pkg::*;
#(
  parameter int unsigned PENDING_SLOTS = PendingDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pend_cmd_t   cmd_i,
  input  logic [31:0] look_seq_i,
  output pend_stat_t  stat_o
);

  localparam int unsigned PIdxW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

  logic [PENDING_SLOTS-1:0] pv_q;
  logic [31:0]              ps_q [PENDING_SLOTS];
  logic [PIdxW-1:0]         free_idx;
  pend_stat_t               stat;

  always_comb begin
    stat     = '0;
    free_idx = '0;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      if (pv_q[i]) begin
        stat.count = stat.count + PendCntW'(1);
        if (ps_q[i] == look_seq_i) begin
          stat.known = 1'b1;
        end
      end else if (!stat.free_found) begin
        stat.free_found = 1'b1;
        free_idx        = PIdxW'(i);
      end
    end
  end

  assign stat_o = stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      for (int i = 0; i < PENDING_SLOTS; i++) begin
        if (cmd_i.clr && pv_q[i] && ps_q[i] == cmd_i.seq) begin
          pv_q[i] <= 1'b0;
        end
      end
      if (cmd_i.alloc && stat.free_found) begin
        pv_q[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc && stat.free_found) begin
      ps_q[free_idx] <= cmd_i.seq;
    end
  end

endmodule

@@ rtl/packet_resequencer_unit.sv @@
// top level of the packet resequencer
//
// Reorders packets by sequence number through a window store of WINDOW slots held in
// one synchronous memory. After reset the store is cleared slot by slot, during
// which in_stall_o stays high (configuration writes are taken at any time). One packet
// is taken at a time. A new packet's slot is read when it is taken and, if free,
// written in ST_CLASS once a result can be staged, and the drain then reads the
// head slot; a late or rejected packet skips the lookup. Each in-order delivery
// clears its slot and reads the next head slot; at a gap ST_REQ checks for a
// request, and the transaction closes in ST_FIN. in_stall_o stays high until then,
// and longer while the output is stalled. Up to MaxResults results follow one packet.
module packet_resequencer_unit
  import rsq_pkg::*;
#(
  parameter int unsigned WINDOW        = WindowDefault,
  parameter int unsigned PENDING_SLOTS = PendingDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] packet_seq_i,
  input  logic        is_retrans_response_i,
  input  logic [15:0] payload_handle_i,
  input  logic [15:0] payload_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] result_seq_o,
  output logic [15:0] out_handle_o,
  output logic [15:0] out_length_o,
  output logic        last_o
);

  localparam int unsigned IdxW  = $clog2(WINDOW);
  localparam int unsigned HeldW = $clog2(WINDOW + 1);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_CLASS    = 3'd2;
  localparam logic [2:0] ST_DRAIN_RD = 3'd3;
  localparam logic [2:0] ST_DRAIN    = 3'd4;
  localparam logic [2:0] ST_REQ      = 3'd5;
  localparam logic [2:0] ST_FIN      = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [31:0]        total_q;
  logic [5:0]         thr_q;
  logic [3:0]         maxp_q;
  logic [31:0]        ne_q, ne_d;
  logic [IdxW-1:0]    base_q, base_d, base_inc;
  logic [IdxW-1:0]    slot_q, slot_d, slot_new;
  logic [IdxW-1:0]    clr_q, clr_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic               done_q, done_d;
  logic [ResCntW-1:0] n_q, n_d;
  logic [15:0]        hnd_q, hnd_d, len_q, len_d;
  logic [31:0]        seq_q, seq_d;
  res_t               hold_q, hold_d;
  logic               hold_valid_q, hold_valid_d;
  res_t               out_q, out_d;
  logic               out_last_q, out_last_d;
  logic               out_valid_q, out_valid_d;

  logic [32:0]        mem [WINDOW];
  logic [32:0]        rd_q;
  logic               mem_we, mem_re;
  logic [IdxW-1:0]    mem_waddr, mem_raddr;
  logic [32:0]        mem_wdata;

  pend_cmd_t          pcmd;
  pend_stat_t         pstat;

  logic               accept, out_free, can, all_deliv, prod_en, fin_en;
  res_t               prod_res;
  logic [31:0]        seq_off;
  logic [IdxW:0]      slot_sum;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign can         = !hold_valid_q || out_free;
  assign all_deliv   = (ne_q - 32'd1) == total_q;
  assign seq_off     = packet_seq_i - ne_q;
  assign slot_sum    = {1'b0, base_q} + {1'b0, seq_off[IdxW-1:0]};
  assign slot_new    = (slot_sum >= (IdxW+1)'(WINDOW)) ?
                       IdxW'(slot_sum - (IdxW+1)'(WINDOW)) : slot_sum[IdxW-1:0];
  assign base_inc    = (base_q == IdxW'(WINDOW - 1)) ? '0 : base_q + IdxW'(1);

  always_comb begin
    state_d   = state_q;
    ne_d      = ne_q;
    base_d    = base_q;
    slot_d    = slot_q;
    clr_d     = clr_q;
    held_d    = held_q;
    done_d    = done_q;
    hnd_d     = hnd_q;
    len_d     = len_q;
    seq_d     = seq_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = base_q;
    prod_en   = 1'b0;
    prod_res  = '{kind: KIND_DROP, seq: packet_seq_i, handle: 16'd0, length: 16'd0};
    fin_en    = 1'b0;
    pcmd      = '{clr: 1'b0, alloc: 1'b0, seq: ne_q};

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == IdxW'(WINDOW - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && !done_q) begin
          if (all_deliv) begin
            prod_en  = 1'b1;
            prod_res = '{kind: KIND_COMPLETE, seq: ne_q - 32'd1, handle: 16'd0,
                         length: 16'd0};
            done_d   = 1'b1;
            state_d  = ST_FIN;
          end else begin
            pcmd  = '{clr: is_retrans_response_i, alloc: 1'b0, seq: packet_seq_i};
            hnd_d = payload_handle_i;
            len_d = payload_length_i;
            seq_d = packet_seq_i;
            if (packet_seq_i < ne_q) begin
              prod_en = 1'b1;
              state_d = ST_DRAIN_RD;
            end else if (seq_off >= 32'(WINDOW)) begin
              prod_en       = 1'b1;
              prod_res.kind = KIND_REJECT;
              state_d       = ST_DRAIN_RD;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = slot_new;
              slot_d    = slot_new;
              state_d   = ST_CLASS;
            end
          end
        end
      end
      ST_CLASS: begin
        if (can) begin
          if (rd_q[32]) begin
            prod_en      = 1'b1;
            prod_res.seq = seq_q;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, hnd_q, len_q};
            held_d    = held_q + HeldW'(1);
          end
          state_d = ST_DRAIN_RD;
        end
      end
      ST_DRAIN_RD: begin
        mem_re  = 1'b1;
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (all_deliv) begin
          if (can) begin
            prod_en  = 1'b1;
            prod_res = '{kind: KIND_COMPLETE, seq: ne_q - 32'd1, handle: 16'd0,
                         length: 16'd0};
            done_d   = 1'b1;
            state_d  = ST_FIN;
          end
        end else if (!rd_q[32]) begin
          state_d = ST_REQ;
        end else if (n_q >= ResCntW'(MaxResults - 1)) begin
          state_d = ST_FIN;
        end else if (can) begin
          prod_en   = 1'b1;
          prod_res  = '{kind: KIND_DELIVER, seq: ne_q, handle: rd_q[31:16],
                        length: rd_q[15:0]};
          mem_we    = 1'b1;
          mem_waddr = base_q;
          if (held_q != '0) begin
            held_d = held_q - HeldW'(1);
          end
          ne_d      = ne_q + 32'd1;
          base_d    = base_inc;
          mem_re    = 1'b1;
          mem_raddr = base_inc;
        end
      end
      ST_REQ: begin
        if ((HeldW + 6)'(held_q) > (HeldW + 6)'(thr_q) && !pstat.known &&
            pstat.count < PendCntW'(maxp_q) && pstat.free_found) begin
          if (can) begin
            prod_en    = 1'b1;
            prod_res   = '{kind: KIND_REQUEST, seq: ne_q, handle: 16'd0, length: 16'd0};
            pcmd.alloc = 1'b1;
            state_d    = ST_FIN;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!hold_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          fin_en  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // staging: a result enters the output register once the next is known or in ST_FIN
  always_comb begin
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && out_stall_i;
    n_d          = accept ? '0 : n_q;
    if (prod_en) begin
      if (hold_valid_q) begin
        out_d       = hold_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
      hold_d       = prod_res;
      hold_valid_d = 1'b1;
      n_d          = n_d + ResCntW'(1);
    end else if (fin_en) begin
      out_d        = hold_q;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      total_q      <= 32'd0;
      thr_q        <= 6'd48;
      maxp_q       <= 4'd5;
      ne_q         <= 32'd1;
      base_q       <= IdxW'(1);
      clr_q        <= '0;
      held_q       <= '0;
      done_q       <= 1'b0;
      n_q          <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ne_q         <= ne_d;
      base_q       <= base_d;
      clr_q        <= clr_d;
      held_q       <= held_d;
      done_q       <= done_d;
      n_q          <= n_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgTotal:     total_q <= cfg_data_i;
          CfgThreshold: thr_q   <= cfg_data_i[5:0];
          CfgMaxPend:   maxp_q  <= cfg_data_i[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    hnd_q      <= hnd_d;
    len_q      <= len_d;
    seq_q      <= seq_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  // window store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  rsq_pend #(
    .PENDING_SLOTS(PENDING_SLOTS)
  ) u_pend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pcmd),
    .look_seq_i (ne_q),
    .stat_o     (pstat)
  );

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_q.kind;
  assign result_seq_o  = out_q.seq;
  assign out_handle_o  = out_q.handle;
  assign out_length_o  = out_q.length;
  assign last_o        = out_last_q;

  a_held_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(WINDOW))
    else $error("held count beyond window");

  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q && !hold_valid_q)
    else $error("result during clearing pass");

  a_idle_flushed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_valid_q)
    else $error("staged result left behind");

  a_result_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ResCntW'(MaxResults))
    else $error("too many results for one transaction");

  a_done_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("completion flag dropped");

endmodule

@@ tb/sv/packet_resequencer_monitor.sv @@
// channel monitor, in-order release predictor and result comparison for the resequencer
module packet_resequencer_monitor
  import rsq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] packet_seq_i,
  input  logic        is_retrans_response_i,
  input  logic [15:0] payload_handle_i,
  input  logic [15:0] payload_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  result_kind_i,
  input  logic [31:0] result_seq_i,
  input  logic [15:0] out_handle_i,
  input  logic [15:0] out_length_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          owed_count_o,
  output int          checked_count_o,
  output logic [31:0] next_seq_o
);

  typedef struct {
    kind_e       kind;
    logic [31:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
    logic        last;
  } release_t;

  localparam int unsigned Win = WindowDefault;
  localparam int unsigned Pend = PendingDefault;

  release_t    owed_results[$];
  logic [31:0] total_pkts;
  logic [5:0]  occ_threshold;
  logic [3:0]  max_pending;
  logic [31:0] next_seq;
  logic        slot_full [Win];
  logic [15:0] slot_hdl [Win];
  logic [15:0] slot_len [Win];
  int          held;
  logic [31:0] pend_seq [Pend];
  logic        pend_full [Pend];
  logic        done;
  int          fails;
  int          checked;

  assign fail_count_o    = fails;
  assign owed_count_o    = owed_results.size();
  assign checked_count_o = checked;
  assign next_seq_o      = next_seq;

  function automatic release_t mk(kind_e k, logic [31:0] s, logic [15:0] h, logic [15:0] l);
    release_t r;
    r.kind = k;
    r.seq = s;
    r.handle = h;
    r.length = l;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic model_packet(input logic [31:0] seq, input logic resp,
                              input logic [15:0] hdl, input logic [15:0] len);
    release_t    batch[$];
    logic        gap;
    logic        known;
    int          idx;
    int          cnt;
    int          free_at;
    gap = 1'b0;
    if (done) return;
    if (next_seq - 32'd1 == total_pkts) begin
      done = 1'b1;
      batch = {batch, mk(KIND_COMPLETE, next_seq - 32'd1, '0, '0)};
    end else begin
      if (resp) begin
        for (int i = 0; i < Pend; i++) if (pend_full[i] && pend_seq[i] == seq) pend_full[i] = 1'b0;
      end
      if (seq < next_seq) begin
        batch = {batch, mk(KIND_DROP, seq, '0, '0)};
      end else if (seq - next_seq >= Win) begin
        batch = {batch, mk(KIND_REJECT, seq, '0, '0)};
      end else begin
        idx = seq % Win;
        if (slot_full[idx]) begin
          batch = {batch, mk(KIND_DROP, seq, '0, '0)};
        end else begin
          slot_full[idx] = 1'b1;
          slot_hdl[idx] = hdl;
          slot_len[idx] = len;
          held++;
        end
      end
      forever begin
        idx = next_seq % Win;
        if (next_seq - 32'd1 == total_pkts) break;
        if (!slot_full[idx]) begin
          gap = 1'b1;
          break;
        end
        if (batch.size() >= MaxResults - 1) break;
        batch = {batch, mk(KIND_DELIVER, next_seq, slot_hdl[idx], slot_len[idx])};
        slot_full[idx] = 1'b0;
        if (held > 0) held--;
        next_seq++;
      end
      if (next_seq - 32'd1 == total_pkts) begin
        done = 1'b1;
        batch = {batch, mk(KIND_COMPLETE, next_seq - 32'd1, '0, '0)};
      end else if (gap && held > occ_threshold) begin
        known = 1'b0;
        cnt = 0;
        free_at = -1;
        for (int i = 0; i < Pend; i++) begin
          if (pend_full[i]) begin
            cnt++;
            if (pend_seq[i] == next_seq) known = 1'b1;
          end else if (free_at < 0) begin
            free_at = i;
          end
        end
        if (!known && cnt < max_pending && free_at >= 0) begin
          pend_full[free_at] = 1'b1;
          pend_seq[free_at] = next_seq;
          batch = {batch, mk(KIND_REQUEST, next_seq, '0, '0)};
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) owed_results = {owed_results, batch[i]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    release_t e;
    if (!rst_ni) begin
      owed_results.delete();
      total_pkts = '0;
      occ_threshold = 6'd48;
      max_pending = 4'd5;
      next_seq = 32'd1;
      held = 0;
      done = 1'b0;
      fails = 0;
      checked = 0;
      for (int i = 0; i < Win; i++) slot_full[i] = 1'b0;
      for (int i = 0; i < Pend; i++) pend_full[i] = 1'b0;
    end else begin
      // outputs first: a result never comes out in the cycle its packet is taken
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (owed_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("ERROR: unexpected result kind %0d seq %0h", result_kind_i, result_seq_i);
        end else begin
          e = owed_results.pop_front();
          if (result_kind_i != e.kind || result_seq_i != e.seq || out_handle_i != e.handle ||
              out_length_i != e.length || last_i != e.last) begin
            fails++;
            if (fails <= 10)
              $display("ERROR: exp kind %0d seq %0h hdl %0h len %0h last %0b, got %0d %0h %0h %0h %0b",
                       e.kind, e.seq, e.handle, e.length, e.last, result_kind_i, result_seq_i,
                       out_handle_i, out_length_i, last_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgTotal:     total_pkts = cfg_data_i;
          CfgThreshold: occ_threshold = cfg_data_i[5:0];
          CfgMaxPend:   max_pending = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        model_packet(packet_seq_i, is_retrans_response_i, payload_handle_i, payload_length_i);
    end
  end

endmodule

@@ tb/sv/packet_resequencer_unit_tb.sv @@
// testbench top of the packet resequencer: stimulus, flow control and verdict
module packet_resequencer_unit_tb;
  import rsq_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] pkt_seq;
  logic        pkt_resp;
  logic [15:0] pkt_handle;
  logic [15:0] pkt_length;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  res_kind;
  logic [31:0] res_seq;
  logic [15:0] res_handle;
  logic [15:0] res_length;
  logic        res_last;
  int          fail_count;
  int          owed_count;
  int          checked_count;
  logic [31:0] next_seq;
  int          cycles;
  int          sent;
  int          burst_left;
  bit          hold_req;

  packet_resequencer_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .packet_seq_i(pkt_seq),
    .is_retrans_response_i(pkt_resp), .payload_handle_i(pkt_handle),
    .payload_length_i(pkt_length),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .result_kind_o(res_kind),
    .result_seq_o(res_seq), .out_handle_o(res_handle), .out_length_o(res_length),
    .last_o(res_last)
  );

  packet_resequencer_monitor mon (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .packet_seq_i(pkt_seq),
    .is_retrans_response_i(pkt_resp), .payload_handle_i(pkt_handle),
    .payload_length_i(pkt_length),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .result_kind_i(res_kind),
    .result_seq_i(res_seq), .out_handle_i(res_handle), .out_length_i(res_length),
    .last_i(res_last),
    .fail_count_o(fail_count), .owed_count_o(owed_count),
    .checked_count_o(checked_count), .next_seq_o(next_seq)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, with an occasional long hold-off on request
  initial begin
    int  hold_left;
    int  run_left;
    bit  stall_now;
    hold_left = 0;
    run_left = 0;
    stall_now = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left = stall_now ? $urandom_range(1, 6) : $urandom_range(1, 24);
        end
        run_left--;
        out_stall <= stall_now;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_packet(input logic [31:0] seq, input logic resp,
                             input logic [15:0] hdl, input logic [15:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    pkt_seq <= seq;
    pkt_resp <= resp;
    pkt_handle <= hdl;
    pkt_length <= len;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic push_rand(input logic [31:0] seq);
    push_packet(seq, $urandom_range(0, 4) == 0, 16'($urandom), 16'($urandom));
  endtask

  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (owed_count != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // shuffled run of consecutive sequences from the expected one, with some noise mixed in
  task automatic reorder_group(input int span);
    logic [31:0] seqs[$];
    logic [31:0] base;
    logic [31:0] tmp;
    int          j;
    base = next_seq;
    for (int i = 0; i < span; i++) seqs = {seqs, base + 32'(i)};
    for (int i = span - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
    foreach (seqs[i]) begin
      case ($urandom_range(0, 9))
        0: push_rand($urandom);
        1: push_rand(next_seq - $urandom_range(1, 4));
        2: push_packet(next_seq, 1'b1, 16'($urandom), 16'($urandom));
        default: ;
      endcase
      push_rand(seqs[i]);
    end
  endtask

  task automatic random_phase(input int items);
    int start;
    start = sent;
    while (sent - start < items) reorder_group($urandom_range(3, 14));
  endtask

  initial begin
    logic [31:0] s;
    logic [31:0] tgt;
    rst_n = 1'b0;
    cycles = 0;
    sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgTotal;
    cfg_data = '0;
    in_valid = 1'b0;
    pkt_seq = '0;
    pkt_resp = 1'b0;
    pkt_handle = '0;
    pkt_length = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_reg(CfgTotal, 32'd0);
    write_reg(CfgTotal, 32'hFFFF_FFFF);
    write_reg(CfgThreshold, 32'd2);
    write_reg(CfgMaxPend, 32'd8);

    // directed: edges of window, late, duplicate, request, responses
    push_packet(32'd1, 1'b0, 16'h0000, 16'hFFFF);
    push_packet(32'd1, 1'b0, 16'h1111, 16'h2222);
    push_packet(32'd0, 1'b0, 16'hFFFF, 16'h0000);
    push_packet(32'hFFFF_FFFF, 1'b0, 16'h1234, 16'h5678);
    push_packet(32'd66, 1'b0, 16'h00AA, 16'h0055);
    push_packet(32'd65, 1'b0, 16'hA5A5, 16'h5A5A);
    push_packet(32'd3, 1'b0, 16'h0003, 16'h0030);
    push_packet(32'd4, 1'b0, 16'h0004, 16'h0040);
    push_packet(32'd5, 1'b0, 16'h0005, 16'h0050);
    push_packet(32'd3, 1'b1, 16'h0333, 16'h0333);
    push_packet(32'd7, 1'b1, 16'h0007, 16'h0070);
    push_packet(32'd2, 1'b1, 16'hFFFF, 16'h0000);
    push_packet(32'd6, 1'b0, 16'h8000, 16'h8000);
    settle();

    write_reg(CfgThreshold, 32'd48);
    write_reg(CfgMaxPend, 32'd5);
    hold_req = 1'b1;
    random_phase(30);
    settle();

    // full window behind a missing head, then the head: drain stops at the cap
    write_reg(CfgThreshold, 32'd63);
    write_reg(CfgMaxPend, 32'd0);
    s = next_seq;
    for (int i = 63; i >= 1; i--) push_rand(s + 32'(i));
    push_rand(s);
    push_rand(s + 64);
    settle();

    write_reg(CfgThreshold, 32'd0);
    write_reg(CfgMaxPend, 32'd8);
    random_phase(30);
    settle();

    write_reg(CfgThreshold, 32'd3);
    write_reg(CfgMaxPend, 32'd2);
    random_phase(25);
    settle();

    // close the transfer three packets ahead, then the block ignores traffic
    tgt = next_seq + 32'd2;
    write_reg(CfgTotal, tgt);
    push_rand(tgt);
    push_rand(tgt - 1);
    push_rand(tgt - 2);
    push_rand($urandom);
    push_rand(tgt + 1);
    settle();

    $display("sent %0d packets over five register settings, %0d results checked",
             sent, checked_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still owed", fail_count, owed_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rsq_pkg.sv
rtl/rsq_pend.sv
rtl/packet_resequencer_unit.sv
tb/sv/packet_resequencer_monitor.sv
tb/sv/packet_resequencer_unit_tb.sv
